// ----- sv/cqe_pkg.sv -----
// shared types and constants of the circular linked queue engine
package cqe_pkg;

  localparam int NUM_ELEMENTS_DEF = 64;
  localparam int NUM_QUEUES_DEF   = 4;

  localparam int REQ_W  = 2;
  localparam int QID_W  = 2;
  localparam int ELEM_W = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam int CNT_MAX = (1 << CNT_W) - 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SIZE   = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_QUEUED    = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ----- sv/circular_linked_queue_engine.sv -----
// Circular doubly linked queue engine: a pool of NUM_ELEMENTS elements linked into
// NUM_QUEUES circular queues through next and prev link memories, one head per queue.
// A request (append, remove or size) is taken when the engine is idle and answers with
// exactly one result. Membership is checked through the owning queue stored beside each
// next link and a queued bit, and each queue keeps a running count, so no list is ever
// walked. A request passes through ST_LINK and ST_DONE before the next one is accepted; an
// append to a non-empty queue also passes through ST_TAIL, because each link memory has a
// single write port and the tail must be relinked in a second write after the registered
// read of the head's prev link.
// The output register lets the next request be taken while a result waits for out_tready.
module circular_linked_queue_engine
  import cqe_pkg::*;
#(
  parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF,
  parameter int NUM_QUEUES   = NUM_QUEUES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // queue_id[1:0], element[7:2]
  input  logic [REQ_W-1:0]      in_tuser,   // req_type[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], removed_element[7:2],
                                            // queue_count[14:8], zero[15]
);

  localparam int EW = $clog2(NUM_ELEMENTS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NW = $clog2(NUM_ELEMENTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LINK = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // link memories; the owning queue sits above each next link
  logic [QW+EW-1:0] next_mem [NUM_ELEMENTS];
  logic [EW-1:0]    prev_mem [NUM_ELEMENTS];
  logic [EW-1:0] next_rd_r, prev_rd_r;
  logic [QW-1:0] owner_rd_r;

  logic          next_we, prev_we;
  logic [EW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  // per-element and per-queue state
  logic [NUM_ELEMENTS-1:0] queued_r;
  logic [NUM_QUEUES-1:0]   nonempty_r;
  logic [EW-1:0]           head_r  [NUM_QUEUES];
  logic [NW-1:0]           count_r [NUM_QUEUES];

  // latched request
  req_t              req_r;
  logic [QID_W-1:0]  qid_r;
  logic [ELEM_W-1:0] elem_r;
  status_t           stat_r;
  logic [EW-1:0]     e_idx;
  logic [QW-1:0]     q_idx;
  logic              qok, eok;

  logic              in_fire;
  req_t              in_req;
  logic [EW-1:0]     in_e_idx;
  logic [QW-1:0]     in_q_idx;
  logic [EW-1:0]     prev_raddr;

  status_t           stat_c;
  logic              do_append, do_remove, out_load;

  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [CNT_W-1:0]  count_sat;
  logic [ELEM_W-1:0] removed_c;

  assign in_fire  = in_tvalid && in_tready;
  assign in_req   = req_t'(in_tuser);
  assign in_q_idx = QW'(in_tdata[QID_W-1:0]);
  assign in_e_idx = EW'(in_tdata[QID_W +: ELEM_W]);
  // append needs the tail, which is the prev link of the head
  assign prev_raddr = (in_req == REQ_APPEND) ? head_r[in_q_idx] : in_e_idx;

  assign e_idx = EW'(elem_r);
  assign q_idx = QW'(qid_r);
  assign qok   = (int'(qid_r) < NUM_QUEUES);
  assign eok   = (int'(elem_r) < NUM_ELEMENTS);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // outcome of the request, valid in ST_LINK once the owner read has returned
  always_comb begin
    stat_c = STAT_OK;
    unique case (req_r)
      REQ_APPEND: begin
        priority if (!qok)            stat_c = STAT_EMPTY;
        else if (!eok)                stat_c = STAT_NOT_FOUND;
        else if (queued_r[e_idx])     stat_c = STAT_QUEUED;
        else                          stat_c = STAT_OK;
      end
      REQ_REMOVE: begin
        priority if (!qok || !nonempty_r[q_idx])              stat_c = STAT_EMPTY;
        else if (!eok || !queued_r[e_idx] || owner_rd_r != q_idx) stat_c = STAT_NOT_FOUND;
        else                                                  stat_c = STAT_OK;
      end
      default: stat_c = STAT_OK;
    endcase
  end

  assign do_append = (state_r == ST_LINK) && (req_r == REQ_APPEND) && (stat_c == STAT_OK);
  assign do_remove = (state_r == ST_LINK) && (req_r == REQ_REMOVE) && (stat_c == STAT_OK);

  // link memory write ports; every next link written belongs to the addressed queue
  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = e_idx;
    next_wdata = e_idx;
    prev_waddr = e_idx;
    prev_wdata = e_idx;
    if (do_append) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      if (nonempty_r[q_idx]) begin
        next_wdata = head_r[q_idx];
        prev_wdata = prev_rd_r;
      end
    end else if (do_remove) begin
      prev_we    = 1'b1;
      prev_waddr = next_rd_r;
      prev_wdata = prev_rd_r;
      next_we    = 1'b1;
      next_waddr = prev_rd_r;
      next_wdata = next_rd_r;
    end else if (state_r == ST_TAIL) begin
      // head's prev and old tail's next now point at the new element
      prev_we    = 1'b1;
      prev_waddr = head_r[q_idx];
      next_we    = 1'b1;
      next_waddr = prev_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= {q_idx, next_wdata};
    if (in_fire) {owner_rd_r, next_rd_r} <= next_mem[in_e_idx];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (in_fire) prev_rd_r <= prev_mem[prev_raddr];
  end

  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LINK;
      ST_LINK: begin
        if (do_append && nonempty_r[q_idx]) state_nxt = ST_TAIL;
        else                                state_nxt = ST_DONE;
      end
      ST_TAIL: state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      queued_r   <= '0;
      nonempty_r <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (do_append) begin
        queued_r[e_idx]   <= 1'b1;
        nonempty_r[q_idx] <= 1'b1;
        count_r[q_idx]    <= count_r[q_idx] + NW'(1);
        if (!nonempty_r[q_idx]) head_r[q_idx] <= e_idx;
      end
      if (do_remove) begin
        queued_r[e_idx] <= 1'b0;
        count_r[q_idx]  <= count_r[q_idx] - NW'(1);
        // sole element links to itself
        if (next_rd_r == e_idx)        nonempty_r[q_idx] <= 1'b0;
        else if (head_r[q_idx] == e_idx) head_r[q_idx]   <= next_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= in_req;
      qid_r  <= in_tdata[QID_W-1:0];
      elem_r <= in_tdata[QID_W +: ELEM_W];
    end
    if (state_r == ST_LINK) stat_r <= stat_c;
  end

  // count as it stands after the request, saturated to the field
  always_comb begin
    count_sat = '0;
    if (qok) begin
      if (int'(count_r[q_idx]) > CNT_MAX) count_sat = CNT_W'(CNT_MAX);
      else                                count_sat = CNT_W'(count_r[q_idx]);
    end
  end

  assign removed_c = (req_r == REQ_REMOVE && stat_r == STAT_OK) ? elem_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_tdata_r <= {1'b0, count_sat, removed_c, stat_r};
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_refused_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STAT_W-1:0] != STAT_OK) |-> (out_tdata[STAT_W +: ELEM_W] == '0))
    else $error("refused request reports a removed element");

  a_count_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    nonempty_r[0] == (count_r[0] != '0))
    else $error("queue count disagrees with non-empty flag");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && (state_r == ST_IDLE))
    else $error("finished request produced no result");

endmodule
